>>> design/depth_to_gray_normalizer_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the depth-to-gray normalizer
// Concurrent checks clocked on aclk and held off while aresetn is low;
// they compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DEPTH_TO_GRAY_NORMALIZER_DEFINES_SVH
`define DEPTH_TO_GRAY_NORMALIZER_DEFINES_SVH

`ifndef SYNTHESIS
// prop must hold at every clock edge out of reset
`define DTGN_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("dtgn assertion failed");
// expr must never be true out of reset
`define DTGN_NEVER(lbl, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error("dtgn forbidden condition seen");
`else
`define DTGN_ASSERT(lbl, prop)
`define DTGN_NEVER(lbl, expr)
`endif

`endif

>>> design/dtgn_pkg.sv
// ----------------------------------------------------------------------------
// dtgn_pkg
// Shared constants, codes and types of the depth-to-gray normalizer.
// ----------------------------------------------------------------------------
package dtgn_pkg;

    // pixel and gray widths
    localparam int DEPTH_W = 16;
    localparam int GRAY_W  = 8;

    localparam logic signed [DEPTH_W-1:0] DISPARITY_LIMIT = 16'sd2047;
    localparam logic signed [DEPTH_W-1:0] STAT_MIN_RESET  = 16'sd2048;
    localparam logic signed [DEPTH_W-1:0] STAT_MAX_RESET  = 16'sd0;

    localparam logic [GRAY_W-1:0] GRAY_BASE    = 8'd64;
    localparam logic [GRAY_W-1:0] GRAY_TOP     = 8'd255;
    localparam logic [GRAY_W-1:0] GRAY_INVALID = 8'd0;

    // divider operand widths: signed numerator/denominator, unsigned magnitudes
    localparam int NUM_W           = 25;
    localparam int DEN_W           = 17;
    localparam int QMAG_W          = 24;
    localparam int DMAG_W          = 16;
    localparam int STEPS_PER_CYCLE = 2;
    localparam int DIV_CYCLES      = QMAG_W / STEPS_PER_CYCLE;
    localparam int CNT_W           = $clog2(DIV_CYCLES + 1);

    // command queue (depth must be a power of two for pointer wrap)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // opcodes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_STAT  = 2'd1;
    localparam logic [1:0] OP_MAP   = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // depth formats
    localparam logic [1:0] FMT_DISPARITY = 2'd0;
    localparam logic [1:0] FMT_MM        = 2'd1;
    localparam logic [1:0] FMT_100UM     = 2'd2;

    // register indexes (paddr[2])
    localparam int         REG_IDX_W        = 1;
    localparam logic [0:0] REG_DEPTH_FORMAT = 1'b0;
    localparam logic [0:0] REG_INVERSE_MODE = 1'b1;

    typedef struct packed {
        logic [1:0] depth_format;
        logic       inverse_mode;
    } cfg_t;

    // one mapping job for the back end
    typedef struct packed {
        logic                     use_div;
        logic                     invert;
        logic [GRAY_W-1:0]        fixed_gray;
        logic signed [NUM_W-1:0]  num;
        logic signed [DEN_W-1:0]  den;
    } cmd_t;

    typedef struct packed {
        logic push;
        cmd_t cmd;
    } q_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

>>> design/dtgn_front.sv
// ----------------------------------------------------------------------------
// dtgn_front
// Accepts transactions, keeps the running min/max and turns each mapping
// pixel into a divide job (or a fixed gray level) for the command queue.
// ----------------------------------------------------------------------------
`include "depth_to_gray_normalizer_defines.svh"

module dtgn_front (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  dtgn_pkg::cfg_t                          cfg,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [1:0]                              s_opcode,
    input  logic signed [dtgn_pkg::DEPTH_W-1:0]     s_depth_value,
    input  dtgn_pkg::q_status_t                     q_status,
    output dtgn_pkg::q_push_t                       q_push
);

    logic signed [dtgn_pkg::DEPTH_W-1:0] running_max_reg, running_max_next;
    logic signed [dtgn_pkg::DEPTH_W-1:0] running_min_reg, running_min_next;

    logic                               accept;
    logic                               pix_valid;
    logic signed [dtgn_pkg::DEN_W-1:0]  d_x;
    logic signed [dtgn_pkg::DEN_W-1:0]  min_x;
    logic signed [dtgn_pkg::DEN_W-1:0]  max_x;
    logic signed [dtgn_pkg::DEN_W-1:0]  diff;
    logic signed [dtgn_pkg::NUM_W-1:0]  diff_w;
    logic signed [dtgn_pkg::NUM_W-1:0]  d_w;
    logic signed [dtgn_pkg::NUM_W-1:0]  norm_num;
    logic signed [dtgn_pkg::NUM_W-1:0]  inv_num;
    dtgn_pkg::cmd_t                     cmd;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        case (cfg.depth_format)
            dtgn_pkg::FMT_DISPARITY: pix_valid = (s_depth_value >= 0) &&
                                                 (s_depth_value < dtgn_pkg::DISPARITY_LIMIT);
            dtgn_pkg::FMT_MM:        pix_valid = (s_depth_value > 0);
            dtgn_pkg::FMT_100UM:     pix_valid = (s_depth_value > 0);
            default:                 pix_valid = 1'b0;
        endcase
    end

    // numerators by shift-add: x*191 = 256x - 64x - x, x*255 = 256x - x
    assign d_x      = dtgn_pkg::DEN_W'(s_depth_value);
    assign min_x    = dtgn_pkg::DEN_W'(running_min_reg);
    assign max_x    = dtgn_pkg::DEN_W'(running_max_reg);
    assign diff     = d_x - min_x;
    assign diff_w   = dtgn_pkg::NUM_W'(diff);
    assign d_w      = dtgn_pkg::NUM_W'(s_depth_value);
    assign norm_num = (diff_w <<< 8) - (diff_w <<< 6) - diff_w;
    assign inv_num  = (d_w <<< 8) - d_w;

    always_comb begin
        cmd.use_div    = 1'b0;
        cmd.invert     = cfg.inverse_mode;
        cmd.fixed_gray = dtgn_pkg::GRAY_INVALID;
        cmd.num        = norm_num;
        cmd.den        = max_x - min_x;
        if (cfg.inverse_mode) begin
            cmd.num = inv_num;
            cmd.den = max_x;
            if (s_depth_value < 0) begin
                cmd.fixed_gray = dtgn_pkg::GRAY_TOP;
            end else begin
                cmd.use_div = 1'b1;
            end
        end else begin
            cmd.use_div = pix_valid;
        end
    end

    assign q_push.push = accept && (s_opcode == dtgn_pkg::OP_MAP);
    assign q_push.cmd  = cmd;

    always_comb begin
        running_max_next = running_max_reg;
        running_min_next = running_min_reg;
        if (accept) begin
            case (s_opcode)
                dtgn_pkg::OP_CLEAR: begin
                    running_max_next = dtgn_pkg::STAT_MAX_RESET;
                    running_min_next = dtgn_pkg::STAT_MIN_RESET;
                end
                dtgn_pkg::OP_STAT: begin
                    if (pix_valid && (s_depth_value > running_max_reg)) begin
                        running_max_next = s_depth_value;
                    end
                    if (pix_valid && (s_depth_value < running_min_reg)) begin
                        running_min_next = s_depth_value;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_max_reg <= dtgn_pkg::STAT_MAX_RESET;
            running_min_reg <= dtgn_pkg::STAT_MIN_RESET;
        end else begin
            running_max_reg <= running_max_next;
            running_min_reg <= running_min_next;
        end
    end

    // statistics only ever move inward from their clear values
    `DTGN_NEVER(a_min_above_clear, running_min_reg > dtgn_pkg::STAT_MIN_RESET)
    `DTGN_NEVER(a_max_negative, running_max_reg < dtgn_pkg::STAT_MAX_RESET)

endmodule

>>> design/dtgn_queue.sv
// ----------------------------------------------------------------------------
// dtgn_queue
// Two-entry command FIFO between the front end and the divider back end.
// ----------------------------------------------------------------------------
`include "depth_to_gray_normalizer_defines.svh"

module dtgn_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dtgn_pkg::q_push_t    q_push,
    input  logic                 pop,
    output dtgn_pkg::q_status_t  q_status,
    output dtgn_pkg::cmd_t       head
);

    dtgn_pkg::cmd_t                    entry_reg [dtgn_pkg::QUEUE_DEPTH];
    logic [dtgn_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [dtgn_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [dtgn_pkg::QCNT_W-1:0]       count_reg, count_next;
    logic                              do_pop;

    assign q_status.full  = (count_reg == dtgn_pkg::QCNT_W'(dtgn_pkg::QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign head           = entry_reg[rd_ptr_reg];
    assign do_pop         = pop && !q_status.empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (q_push.push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (q_push.push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!q_push.push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_push.push) begin
            entry_reg[wr_ptr_reg] <= q_push.cmd;
        end
    end

    `DTGN_NEVER(a_push_when_full, q_push.push && q_status.full)
    `DTGN_NEVER(a_count_overflow, count_reg > dtgn_pkg::QCNT_W'(dtgn_pkg::QUEUE_DEPTH))

endmodule

>>> design/dtgn_back.sv
// ----------------------------------------------------------------------------
// dtgn_back
// Pops mapping jobs, runs a signed divide two quotient bits per cycle and
// holds the gray level in the output register.
// ----------------------------------------------------------------------------
`include "depth_to_gray_normalizer_defines.svh"

module dtgn_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  dtgn_pkg::q_status_t                q_status,
    input  dtgn_pkg::cmd_t                     head,
    output logic                               pop,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [dtgn_pkg::GRAY_W-1:0]        m_gray_level
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam int STEP_W = dtgn_pkg::DMAG_W + dtgn_pkg::QMAG_W;

    function automatic logic [STEP_W-1:0] div_step(
        input logic [dtgn_pkg::DMAG_W-1:0] rem,
        input logic [dtgn_pkg::QMAG_W-1:0] quo,
        input logic [dtgn_pkg::DMAG_W-1:0] dv
    );
        logic [dtgn_pkg::DMAG_W:0]   r_sh;
        logic [dtgn_pkg::QMAG_W-1:0] q_sh;
        r_sh = {rem, quo[dtgn_pkg::QMAG_W-1]};
        q_sh = {quo[dtgn_pkg::QMAG_W-2:0], 1'b0};
        if (r_sh >= {1'b0, dv}) begin
            r_sh    = r_sh - {1'b0, dv};
            q_sh[0] = 1'b1;
        end
        return {r_sh[dtgn_pkg::DMAG_W-1:0], q_sh};
    endfunction

    logic [1:0]                        state_reg, state_next;
    logic [dtgn_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic [dtgn_pkg::DMAG_W-1:0]       rem_reg, rem_next;
    logic [dtgn_pkg::QMAG_W-1:0]       quo_reg, quo_next;
    logic [dtgn_pkg::DMAG_W-1:0]       dmag_reg;
    logic                              neg_reg;
    logic                              den_zero_reg;
    logic                              use_div_reg;
    logic                              invert_reg;
    logic [dtgn_pkg::GRAY_W-1:0]       fixed_reg;
    logic                              m_valid_reg, m_valid_next;
    logic [dtgn_pkg::GRAY_W-1:0]       m_gray_reg;

    logic                              load;
    logic                              load_out;
    logic                              div_last;
    logic signed [dtgn_pkg::NUM_W-1:0] num_abs;
    logic signed [dtgn_pkg::DEN_W-1:0] den_abs;
    logic [STEP_W-1:0]                 step_acc;
    logic [dtgn_pkg::GRAY_W-1:0]       q8;
    logic [dtgn_pkg::GRAY_W-1:0]       q8_signed;
    logic [dtgn_pkg::GRAY_W-1:0]       gray;

    assign load     = (state_reg == ST_IDLE) && !q_status.empty;
    assign pop      = load;
    assign load_out = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    assign div_last = (state_reg == ST_DIV) &&
                      (cnt_reg == dtgn_pkg::CNT_W'(dtgn_pkg::DIV_CYCLES - 1));

    assign num_abs = head.num[dtgn_pkg::NUM_W-1] ? -head.num : head.num;
    assign den_abs = head.den[dtgn_pkg::DEN_W-1] ? -head.den : head.den;

    always_comb begin
        step_acc = {rem_reg, quo_reg};
        for (int i = 0; i < dtgn_pkg::STEPS_PER_CYCLE; i++) begin
            step_acc = div_step(step_acc[STEP_W-1:dtgn_pkg::QMAG_W],
                                step_acc[dtgn_pkg::QMAG_W-1:0], dmag_reg);
        end
    end

    // truncating signed quotient, low byte only; zero divisor gives zero
    assign q8        = den_zero_reg ? '0 : quo_reg[dtgn_pkg::GRAY_W-1:0];
    assign q8_signed = neg_reg ? (~q8 + 1'b1) : q8;
    assign gray      = !use_div_reg ? fixed_reg :
                       invert_reg   ? (dtgn_pkg::GRAY_TOP - q8_signed) :
                                      (dtgn_pkg::GRAY_BASE + q8_signed);

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (load) begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    quo_next   = num_abs[dtgn_pkg::QMAG_W-1:0];
                    state_next = head.use_div ? ST_DIV : ST_DONE;
                end
            end
            ST_DIV: begin
                rem_next = step_acc[STEP_W-1:dtgn_pkg::QMAG_W];
                quo_next = step_acc[dtgn_pkg::QMAG_W-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (div_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (load) begin
            dmag_reg     <= den_abs[dtgn_pkg::DMAG_W-1:0];
            neg_reg      <= head.num[dtgn_pkg::NUM_W-1] ^ head.den[dtgn_pkg::DEN_W-1];
            den_zero_reg <= (head.den == '0);
            use_div_reg  <= head.use_div;
            invert_reg   <= head.invert;
            fixed_reg    <= head.fixed_gray;
        end
        if (load_out) begin
            m_gray_reg <= gray;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_gray_level = m_gray_reg;

    `DTGN_NEVER(a_no_overwrite, load_out && m_valid_reg && !m_ready)
    `DTGN_ASSERT(a_div_ends, div_last |=> (state_reg == ST_DONE))

endmodule

>>> design/depth_to_gray_normalizer.sv
// ----------------------------------------------------------------------------
// depth_to_gray_normalizer
// Streams a depth frame twice: a statistics pass collecting min/max of the
// valid pixels, then a mapping pass producing one gray byte per pixel.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  s_        in         s_valid / s_ready      s_opcode[1:0], s_depth_value[15:0]
//  m_        out        m_valid / m_ready      m_gray_level[7:0]
//  apb       in         psel/penable/pready    paddr[2:0], pwdata/prdata[31:0]
//
//  In the back end a mapping job is popped, divided (24-bit quotient, two bits
//  per cycle) and loaded into the output register once that is free. Fixed
//  gray jobs (invalid pixels outside inverse mode, negative pixels in it) skip
//  the divider. Clear and statistics transactions finish in the front end.
//  The 2-entry job queue lets the front end keep taking transactions while
//  the divider runs or the result waits on m_ready.
//  Synchronous active-low reset clears statistics, config and the queue.
// ----------------------------------------------------------------------------

module depth_to_gray_normalizer (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // input stream
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [1:0]                            s_opcode,
    input  logic signed [dtgn_pkg::DEPTH_W-1:0]   s_depth_value,
    // result stream
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [dtgn_pkg::GRAY_W-1:0]           m_gray_level,
    // register port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [2:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    // --- configuration registers -------------------------------------------
    // Register select is paddr[2]; low address bits are don't-care.
    logic [1:0]                          depth_format_reg;
    logic                                inverse_mode_reg;
    logic                                cfg_wr;
    logic [dtgn_pkg::REG_IDX_W-1:0]      reg_idx;
    dtgn_pkg::cfg_t                      cfg;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_format_reg <= dtgn_pkg::FMT_DISPARITY;
            inverse_mode_reg <= 1'b0;
        end else if (cfg_wr) begin
            case (reg_idx)
                dtgn_pkg::REG_DEPTH_FORMAT: depth_format_reg <= pwdata[1:0];
                dtgn_pkg::REG_INVERSE_MODE: inverse_mode_reg <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            dtgn_pkg::REG_DEPTH_FORMAT: prdata = {30'd0, depth_format_reg};
            dtgn_pkg::REG_INVERSE_MODE: prdata = {31'd0, inverse_mode_reg};
            default:                    prdata = '0;
        endcase
    end

    assign cfg.depth_format = depth_format_reg;
    assign cfg.inverse_mode = inverse_mode_reg;

    // --- front end: statistics and job build --------------------------------
    // Jobs carry fully formed numerator/denominator, so a later clear or
    // statistics transaction cannot disturb a job still waiting in the queue.
    dtgn_pkg::q_push_t   q_push;
    dtgn_pkg::q_status_t q_status;
    dtgn_pkg::cmd_t      head;
    logic                pop;

    dtgn_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_depth_value (s_depth_value),
        .q_status      (q_status),
        .q_push        (q_push)
    );

    // --- job queue ------------------------------------------------------------
    dtgn_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_push   (q_push),
        .pop      (pop),
        .q_status (q_status),
        .head     (head)
    );

    // --- back end: serial divider and output register ------------------------
    dtgn_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_status     (q_status),
        .head         (head),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_gray_level (m_gray_level)
    );

endmodule
